// ===== src/mclw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mclw_pkg;

  // Field widths
  localparam int REQ_W     = 3;
  localparam int CH_W      = 3;
  localparam int VAL_W     = 32;
  localparam int TIME_W    = 31;
  localparam int ID_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Table size and scan limits
  localparam int CHANNELS_DEF = 8;
  localparam int MAX_RESULTS  = 8;
  localparam int NF_W         = $clog2(MAX_RESULTS + 1);

  // Configuration reset values
  localparam logic [TIME_W-1:0] DEF_TIMEOUT = 31'd100;
  localparam logic [TIME_W-1:0] DEF_GRACE   = 31'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_GRACE   = 2'd1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_REGISTER = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FEED     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_TMO  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SCAN     = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_VALUE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_CH = 2'd3;

  // Channel table write controls
  typedef struct packed {
    logic we_timeout;
    logic we_deadline;
    logic we_fed;
    logic fed_val;
    logic we_notified;
    logic notified_val;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== src/multi_channel_liveness_watchdog_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Multi-channel liveness watchdog. Keeps a millisecond clock and a table of
// CHANNELS watchdog channels handed out in order by register requests; feed,
// set timeout and query address one channel, tick advances the clock, and a
// scan reports each registered channel whose deadline is newly reached, in
// ascending order, at most eight per scan, with last on the final report (a
// scan with nothing to report gives no result). Deadlines compare as signed
// 32-bit differences, so clock wrap is harmless. Requests are taken one at a
// time: a non-scan request is accepted, makes one pass through the shared
// adder and gives its result. A scan is accepted, set up, walks the table
// through the single add/subtract unit one channel a cycle while no report
// waits on the output, and ends with a final flush; a scan of an empty table
// ends at setup with no result.
// Configuration writes are always taken.
module multi_channel_liveness_watchdog_core #(
  parameter int CHANNELS = mclw_pkg::CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mclw_pkg::REQ_W-1:0]     req_type,
  input  wire logic [mclw_pkg::CH_W-1:0]      channel,
  input  wire logic [mclw_pkg::VAL_W-1:0]     timeout_value,
  input  wire logic [mclw_pkg::VAL_W-1:0]     grace_value,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [mclw_pkg::STATUS_W-1:0]  status,
  output logic      [mclw_pkg::ID_W-1:0]      channel_id,
  output logic                                online,
  output logic                                notify,
  output logic                                last,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mclw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mclw_pkg::TIME_W-1:0]    cfg_data
);
  import mclw_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int CMP_W = (CNT_W > CH_W) ? CNT_W : CH_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [TIME_W-1:0] default_timeout;
  logic [TIME_W-1:0] default_grace;

  // Block state
  logic [VAL_W-1:0] clock_ms, clock_ms_next;
  logic [CNT_W-1:0] reg_count, reg_count_next;

  // Latched request
  logic [REQ_W-1:0] req, req_next;
  logic [CH_W-1:0]  ch, ch_next;
  logic [VAL_W-1:0] tv, tv_next;
  logic [VAL_W-1:0] gv, gv_next;

  // Table address and scan bookkeeping
  logic [IDX_W-1:0] addr, addr_next;
  logic             scan_active, scan_active_next;
  logic             scan_end, scan_end_next;
  logic             pend_v, pend_v_next;
  logic [IDX_W-1:0] pend_id, pend_id_next;
  logic [NF_W-1:0]  nfound, nfound_next;

  // Result registers
  logic                out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [ID_W-1:0]     channel_id_next;
  logic                online_next, notify_next, last_next;

  // Shared unit and table
  logic [VAL_W-1:0]  alu_b, alu_y;
  logic              alu_sub;
  tbl_wr_t           wr;
  logic [TIME_W-1:0] wr_timeout;
  logic [TIME_W-1:0] rd_timeout;
  logic [VAL_W-1:0]  rd_deadline;
  logic              rd_fed, rd_notified;

  // Decode helpers
  logic [VAL_W-1:0] t_sel, g_sel;
  logic             known, full, expired, at_end;
  logic [NF_W-1:0]  found_n;

  mclw_alu u_alu (
    .a   (clock_ms),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  mclw_table #(
    .CHANNELS (CHANNELS)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .addr        (addr),
    .wr          (wr),
    .wr_timeout  (wr_timeout),
    .wr_deadline (alu_y),
    .rd_timeout  (rd_timeout),
    .rd_deadline (rd_deadline),
    .rd_fed      (rd_fed),
    .rd_notified (rd_notified)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Request decode
  assign t_sel   = (tv != '0) ? tv : {1'b0, default_timeout};
  assign g_sel   = (gv != '0) ? gv : {1'b0, default_grace};
  assign known   = CMP_W'(ch) < CMP_W'(reg_count);
  assign full    = (reg_count == CNT_W'(CHANNELS));
  assign expired = ~rd_notified & ~alu_y[VAL_W-1];
  assign found_n = nfound + NF_W'(expired);
  assign at_end  = ((CNT_W'(addr) + CNT_W'(1)) == reg_count) ||
                   (found_n == NF_W'(MAX_RESULTS));

  // Sequencer
  always_comb begin
    state_next       = state;
    clock_ms_next    = clock_ms;
    reg_count_next   = reg_count;
    req_next         = req;
    ch_next          = ch;
    tv_next          = tv;
    gv_next          = gv;
    addr_next        = addr;
    scan_active_next = scan_active;
    scan_end_next    = scan_end;
    pend_v_next      = pend_v;
    pend_id_next     = pend_id;
    nfound_next      = nfound;
    out_valid_next   = out_valid;
    status_next      = status;
    channel_id_next  = channel_id;
    online_next      = online;
    notify_next      = notify;
    last_next        = last;
    alu_b            = '0;
    alu_sub          = 1'b0;
    wr               = '0;
    wr_timeout       = t_sel[TIME_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next = req_type;
          ch_next  = channel;
          tv_next  = timeout_value;
          gv_next  = grace_value;
          if (req_type == REQ_REGISTER) begin
            addr_next = IDX_W'(reg_count);
          end else if (req_type == REQ_SCAN) begin
            addr_next = '0;
          end else begin
            addr_next = IDX_W'(channel);
          end
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        // single-result requests and scan setup
        out_valid_next  = 1'b1;
        status_next     = ST_OK;
        channel_id_next = '0;
        online_next     = 1'b0;
        notify_next     = 1'b0;
        last_next       = 1'b1;
        state_next      = S_OUT;
        unique case (req)
          REQ_REGISTER: begin
            alu_b = g_sel;
            if (full) begin
              status_next = ST_FULL;
            end else if (t_sel[VAL_W-1] || g_sel[VAL_W-1]) begin
              status_next = ST_BAD_VALUE;
            end else begin
              wr.we_timeout   = 1'b1;
              wr.we_deadline  = 1'b1;
              wr.we_fed       = 1'b1;
              wr.fed_val      = 1'b0;
              wr.we_notified  = 1'b1;
              wr.notified_val = 1'b0;
              wr_timeout      = t_sel[TIME_W-1:0];
              reg_count_next  = reg_count + CNT_W'(1);
              channel_id_next = ID_W'(reg_count);
            end
          end
          REQ_FEED: begin
            alu_b = {1'b0, rd_timeout};
            if (!known) begin
              status_next = ST_UNKNOWN_CH;
            end else begin
              wr.we_deadline  = 1'b1;
              wr.we_fed       = 1'b1;
              wr.fed_val      = 1'b1;
              wr.we_notified  = 1'b1;
              wr.notified_val = 1'b0;
            end
          end
          REQ_SET_TMO: begin
            wr_timeout = tv[TIME_W-1:0];
            if (!known) begin
              status_next = ST_UNKNOWN_CH;
            end else if (tv == '0 || tv[VAL_W-1]) begin
              status_next = ST_BAD_VALUE;
            end else begin
              wr.we_timeout = 1'b1;
            end
          end
          REQ_QUERY: begin
            alu_sub = 1'b1;
            alu_b   = rd_deadline;
            if (!known) begin
              status_next = ST_UNKNOWN_CH;
            end else begin
              online_next = rd_fed & ~rd_notified & alu_y[VAL_W-1];
            end
          end
          REQ_TICK: begin
            alu_b         = VAL_W'(1);
            clock_ms_next = alu_y;
          end
          REQ_SCAN: begin
            out_valid_next = 1'b0;
            if (reg_count == '0) begin
              state_next = S_IDLE;
            end else begin
              scan_active_next = 1'b1;
              scan_end_next    = 1'b0;
              pend_v_next      = 1'b0;
              nfound_next      = '0;
              state_next       = S_SCAN;
            end
          end
          default: begin
            // unknown request: plain ok
          end
        endcase
      end

      S_SCAN: begin
        // one channel a cycle unless a report waits on the output; a report is held back one find to mark last
        alu_sub       = 1'b1;
        alu_b         = rd_deadline;
        addr_next     = addr + IDX_W'(1);
        scan_end_next = at_end;
        state_next    = at_end ? S_FLUSH : S_SCAN;
        if (expired) begin
          wr.we_notified  = 1'b1;
          wr.notified_val = 1'b1;
          nfound_next     = found_n;
          pend_v_next     = 1'b1;
          pend_id_next    = addr;
          if (pend_v) begin
            out_valid_next  = 1'b1;
            status_next     = ST_OK;
            channel_id_next = ID_W'(pend_id);
            online_next     = 1'b0;
            notify_next     = 1'b1;
            last_next       = 1'b0;
            state_next      = S_OUT;
          end
        end
      end

      S_FLUSH: begin
        scan_active_next = 1'b0;
        if (pend_v) begin
          pend_v_next     = 1'b0;
          out_valid_next  = 1'b1;
          status_next     = ST_OK;
          channel_id_next = ID_W'(pend_id);
          online_next     = 1'b0;
          notify_next     = 1'b1;
          last_next       = 1'b1;
          state_next      = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (scan_active) begin
            state_next = scan_end ? S_FLUSH : S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      clock_ms    <= '0;
      reg_count   <= '0;
      scan_active <= 1'b0;
      pend_v      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clock_ms    <= clock_ms_next;
      reg_count   <= reg_count_next;
      scan_active <= scan_active_next;
      pend_v      <= pend_v_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req        <= req_next;
    ch         <= ch_next;
    tv         <= tv_next;
    gv         <= gv_next;
    addr       <= addr_next;
    scan_end   <= scan_end_next;
    pend_id    <= pend_id_next;
    nfound     <= nfound_next;
    status     <= status_next;
    channel_id <= channel_id_next;
    online     <= online_next;
    notify     <= notify_next;
    last       <= last_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= DEF_TIMEOUT;
      default_grace   <= DEF_GRACE;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEFAULT_TIMEOUT) begin
        default_timeout <= cfg_data;
      end else if (cfg_index == REG_DEFAULT_GRACE) begin
        default_grace <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mclw_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared 32-bit add/subtract unit: deadlines, wrap-safe differences, clock tick
module mclw_alu (
  input  wire logic [mclw_pkg::VAL_W-1:0] a,
  input  wire logic [mclw_pkg::VAL_W-1:0] b,
  input  wire logic                       sub,
  output logic      [mclw_pkg::VAL_W-1:0] y
);
  import mclw_pkg::*;

  logic [VAL_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign y    = a + b_op + VAL_W'(sub);

endmodule

`default_nettype wire

// ===== src/mclw_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel table: one shared address for read and write
module mclw_table #(
  parameter int CHANNELS = mclw_pkg::CHANNELS_DEF,
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [IDX_W-1:0]            addr,
  input  wire mclw_pkg::tbl_wr_t           wr,
  input  wire logic [mclw_pkg::TIME_W-1:0] wr_timeout,
  input  wire logic [mclw_pkg::VAL_W-1:0]  wr_deadline,
  output logic      [mclw_pkg::TIME_W-1:0] rd_timeout,
  output logic      [mclw_pkg::VAL_W-1:0]  rd_deadline,
  output logic                             rd_fed,
  output logic                             rd_notified
);
  import mclw_pkg::*;

  logic [TIME_W-1:0] timeout_mem  [CHANNELS];
  logic [VAL_W-1:0]  deadline_mem [CHANNELS];
  logic [CHANNELS-1:0] fed;
  logic [CHANNELS-1:0] notified;

  // Payload storage, written only for allocated channels
  always_ff @(posedge clk) begin
    if (wr.we_timeout) begin
      timeout_mem[addr] <= wr_timeout;
    end
    if (wr.we_deadline) begin
      deadline_mem[addr] <= wr_deadline;
    end
  end

  // Flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fed      <= '0;
      notified <= '0;
    end else begin
      if (wr.we_fed) begin
        fed[addr] <= wr.fed_val;
      end
      if (wr.we_notified) begin
        notified[addr] <= wr.notified_val;
      end
    end
  end

  assign rd_timeout  = timeout_mem[addr];
  assign rd_deadline = deadline_mem[addr];
  assign rd_fed      = fed[addr];
  assign rd_notified = notified[addr];

endmodule

`default_nettype wire
